/* design/pitd_pkg.sv */
// Shared types and constants for the pixel invert, tint and desaturate block.
`default_nettype none

package pitd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int NUM_LANES  = 3;

    // Rec.709 luminance weights with 16 fraction bits; they sum to exactly 65536.
    localparam logic [15:0] LUMA_R = 16'd13933;
    localparam logic [15:0] LUMA_G = 16'd46871;
    localparam logic [15:0] LUMA_B = 16'd4732;

    // Register reset values.
    localparam logic                  RST_MODE_SELECT   = 1'b0;
    localparam logic                  RST_RGB_ENABLE    = 1'b1;
    localparam logic [SAMPLE_W-1:0]   RST_INVERT_AMOUNT = 16'd0;
    localparam logic [GAIN_W-1:0]     RST_GAIN          = 17'd32768;
    localparam logic [SAMPLE_W-1:0]   RST_MIX_STRENGTH  = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE_SELECT   = 3'd0,
        CFG_RGB_ENABLE    = 3'd1,
        CFG_INVERT_AMOUNT = 3'd2,
        CFG_RED_GAIN      = 3'd3,
        CFG_GREEN_GAIN    = 3'd4,
        CFG_BLUE_GAIN     = 3'd5,
        CFG_MIX_STRENGTH  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } t_pix;

endpackage

`default_nettype wire

/* design/pitd_if.sv */
// Channel interfaces: input pixel, output pixel and configuration write.
`default_nettype none

interface pitd_in_if import pitd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface pitd_out_if import pitd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] red_out;
    logic [SAMPLE_W-1:0] green_out;
    logic [SAMPLE_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

interface pitd_cfg_if import pitd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/pitd_luma.sv */
// Two-stage Rec.709 luminance unit that combines the three input samples.
`default_nettype none

module pitd_luma import pitd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [SAMPLE_W-1:0] i_red,
    input  wire logic [SAMPLE_W-1:0] i_green,
    input  wire logic [SAMPLE_W-1:0] i_blue,
    output logic      [SAMPLE_W-1:0] o_lum
);

    logic [31:0]         r_pr, r_pg, r_pb;
    logic [31:0]         n_pr, n_pg, n_pb;
    logic [SAMPLE_W-1:0] r_lum;
    logic [31:0]         w_sum;

    always_comb begin
        n_pr = 32'(i_red)   * 32'(LUMA_R);
        n_pg = 32'(i_green) * 32'(LUMA_G);
        n_pb = 32'(i_blue)  * 32'(LUMA_B);
    end

    // The weights sum to 65536, so the total stays below 2^32.
    assign w_sum = r_pr + r_pg + r_pb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr  <= n_pr;
            r_pg  <= n_pg;
            r_pb  <= n_pb;
            r_lum <= w_sum[31:16];
        end
    end

    assign o_lum = r_lum;

endmodule

`default_nettype wire

/* design/pitd_lane.sv */
// One color lane: invert-tint and desaturate-mix paths over three register stages.
`default_nettype none

module pitd_lane import pitd_pkg::*; #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [GAIN_W-1:0]   i_gain,
    input  wire logic [SAMPLE_W-1:0] i_invert,
    input  wire logic [SAMPLE_W-1:0] i_strength,
    input  wire logic                i_mode,
    input  wire logic                i_bypass,
    input  wire logic [SAMPLE_W-1:0] i_lum,
    output logic      [SAMPLE_W-1:0] o_result
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    // Magnitude of ONE - 2c.
    localparam int AW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int P1W = SAMPLE_W + AW;
    localparam int QW  = P1W - FRAC_BITS;
    localparam int SW  = QW + 1;
    // Any blended value at or above (ONE+1)*ONE clamps the same way, so it saturates.
    localparam int VW  = (QW + 1 < 2 * FRAC_BITS + 1) ? QW + 1 : 2 * FRAC_BITS + 1;
    localparam int P3W = GAIN_W + VW;
    localparam int PW  = P3W - FRAC_BITS;
    localparam int CW  = (PW > FRAC_BITS + 1) ? PW : FRAC_BITS + 1;
    localparam int MQW = 2 * SAMPLE_W - FRAC_BITS;
    localparam int MSW = ((MQW > SAMPLE_W) ? MQW : SAMPLE_W) + 1;
    localparam int MCW = (MSW > FRAC_BITS + 1) ? MSW : FRAC_BITS + 1;

    // Stage 1: invert product.
    logic [P1W-1:0]      r_s1_prod, n_s1_prod;
    logic                r_s1_neg,  n_s1_neg;
    logic [SAMPLE_W-1:0] r_s1_c;
    logic [AW-1:0]       w_two_c, w_one, w_magd;

    // Stage 2: blended value.
    logic [VW-1:0]       r_s2_v,    n_s2_v;
    logic                r_s2_vneg, n_s2_vneg;
    logic [SAMPLE_W-1:0] r_s2_c;
    logic [SW-1:0]       w_q, w_c2, w_sum;

    // Stage 3: gain product and mix product.
    logic [P3W-1:0]      r_s3_gp,   n_s3_gp;
    logic                r_s3_vneg;
    logic [2*SAMPLE_W-1:0] r_s3_mp, n_s3_mp;
    logic                r_s3_mneg, n_s3_mneg;
    logic [SAMPLE_W-1:0] r_s3_c;
    logic [SAMPLE_W-1:0] w_mmag;

    // Final selection.
    logic [CW-1:0]       w_p, w_inv;
    logic [MCW-1:0]      w_mc, w_mq, w_mix;

    always_comb begin
        w_two_c   = AW'({i_sample, 1'b0});
        w_one     = AW'(ONE);
        n_s1_neg  = w_two_c > w_one;
        w_magd    = n_s1_neg ? (w_two_c - w_one) : (w_one - w_two_c);
        n_s1_prod = P1W'(i_invert) * P1W'(w_magd);
    end

    always_comb begin
        w_q       = SW'(r_s1_prod[P1W-1:FRAC_BITS]);
        w_c2      = SW'(r_s1_c);
        n_s2_vneg = r_s1_neg && (w_q > w_c2);
        w_sum     = r_s1_neg ? (w_c2 - w_q) : (w_c2 + w_q);
        if ((w_sum >> VW) != '0) begin
            n_s2_v = '1;
        end else begin
            n_s2_v = w_sum[VW-1:0];
        end
    end

    always_comb begin
        n_s3_gp   = P3W'(i_gain) * P3W'(r_s2_v);
        n_s3_mneg = r_s2_c > i_lum;
        w_mmag    = n_s3_mneg ? (r_s2_c - i_lum) : (i_lum - r_s2_c);
        n_s3_mp   = (2*SAMPLE_W)'(i_strength) * (2*SAMPLE_W)'(w_mmag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_prod <= n_s1_prod;
            r_s1_neg  <= n_s1_neg;
            r_s1_c    <= i_sample;
            r_s2_v    <= n_s2_v;
            r_s2_vneg <= n_s2_vneg;
            r_s2_c    <= r_s1_c;
            r_s3_gp   <= n_s3_gp;
            r_s3_vneg <= r_s2_vneg;
            r_s3_mp   <= n_s3_mp;
            r_s3_mneg <= n_s3_mneg;
            r_s3_c    <= r_s2_c;
        end
    end

    always_comb begin
        w_p = CW'(r_s3_gp[P3W-1:FRAC_BITS]);
        if (r_s3_vneg) begin
            w_inv = '0;
        end else if (w_p > CW'(ONE)) begin
            w_inv = CW'(ONE);
        end else begin
            w_inv = w_p;
        end

        w_mc = MCW'(r_s3_c);
        w_mq = MCW'(r_s3_mp[2*SAMPLE_W-1:FRAC_BITS]);
        priority if (r_s3_mneg && (w_mq > w_mc)) begin
            w_mix = '0;
        end else if (r_s3_mneg) begin
            w_mix = w_mc - w_mq;
        end else begin
            w_mix = w_mc + w_mq;
        end
        if (w_mix > MCW'(ONE)) begin
            w_mix = MCW'(ONE);
        end

        priority if (i_bypass) begin
            o_result = r_s3_c;
        end else if (i_mode) begin
            o_result = w_mix[SAMPLE_W-1:0];
        end else begin
            o_result = w_inv[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* design/pitd_obuf.sv */
// Output register with one skid entry; the upstream ready comes from a register.
`default_nettype none

module pitd_obuf import pitd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_pix i_word,
    output logic      o_space,
    pitd_out_if.source o_pix
);

    logic r_out_v, n_out_v;
    logic r_skid_v, n_skid_v;
    t_pix r_out, r_skid;
    logic w_take_out;

    assign w_take_out = !r_out_v || o_pix.ready;

    always_comb begin
        n_out_v  = w_take_out ? (r_skid_v || i_push) : 1'b1;
        n_skid_v = w_take_out ? 1'b0 : (r_skid_v || i_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_out) begin
            r_out <= r_skid_v ? r_skid : i_word;
        end
        if (!w_take_out && i_push) begin
            r_skid <= i_word;
        end
    end

    assign o_space         = !r_skid_v;
    assign o_pix.valid     = r_out_v;
    assign o_pix.red_out   = r_out.red;
    assign o_pix.green_out = r_out.green;
    assign o_pix.blue_out  = r_out.blue;

endmodule

`default_nettype wire

/* design/pixel_invert_tint_desaturate_top.sv */
// Top level of the pixel invert, tint and desaturate block.
//
//   Channel  Modport  Word                                  Handshake
//   i_pix    sink     red_in, green_in, blue_in (16b each)  valid/ready
//   o_pix    source   red_out, green_out, blue_out          valid/ready
//   i_cfg    sink     index (3b), data (17b)                valid/ready, ready always high
//
// One pixel is accepted per clock while the skid entry is free. A pixel accepted at
// a rising edge passes the three lane register stages (the invert product, the blend,
// the gain and mix products) and then the output register before it shows on o_pix.
// i_rst_n is synchronous and active low; it empties the pipeline and loads the register
// reset values. A stall on o_pix first fills the output register, then the skid entry;
// only a full skid entry drops i_pix.ready and freezes the lanes, so ready is registered.
`default_nettype none

module pixel_invert_tint_desaturate_top import pitd_pkg::*; #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pitd_in_if.sink    i_pix,
    pitd_out_if.source o_pix,
    pitd_cfg_if.sink   i_cfg
);

    // Configuration registers. The user must change them only while no pixel is in
    // flight; the block does not enforce it, and the lanes read them live at every stage.
    logic                r_mode;
    logic                r_rgb;
    logic [SAMPLE_W-1:0] r_invert;
    logic [GAIN_W-1:0]   r_gain [NUM_LANES];
    logic [SAMPLE_W-1:0] r_strength;

    logic [2:0]          r_vld;
    logic                w_en;
    logic                w_take;
    logic                w_push;
    logic                w_bypass;
    logic [SAMPLE_W-1:0] w_lum;
    logic [SAMPLE_W-1:0] w_sample [NUM_LANES];
    logic [SAMPLE_W-1:0] w_result [NUM_LANES];
    t_pix                w_word;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= RST_MODE_SELECT;
            r_rgb      <= RST_RGB_ENABLE;
            r_invert   <= RST_INVERT_AMOUNT;
            r_gain[0]  <= RST_GAIN;
            r_gain[1]  <= RST_GAIN;
            r_gain[2]  <= RST_GAIN;
            r_strength <= RST_MIX_STRENGTH;
        end else if (i_cfg.valid) begin
            // Indexes past the last register are ignored.
            unique case (i_cfg.index)
                CFG_MODE_SELECT:   r_mode     <= i_cfg.data[0];
                CFG_RGB_ENABLE:    r_rgb      <= i_cfg.data[0];
                CFG_INVERT_AMOUNT: r_invert   <= i_cfg.data[SAMPLE_W-1:0];
                CFG_RED_GAIN:      r_gain[0]  <= i_cfg.data[GAIN_W-1:0];
                CFG_GREEN_GAIN:    r_gain[1]  <= i_cfg.data[GAIN_W-1:0];
                CFG_BLUE_GAIN:     r_gain[2]  <= i_cfg.data[GAIN_W-1:0];
                CFG_MIX_STRENGTH:  r_strength <= i_cfg.data[SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances together whenever the skid entry is free.
    assign i_pix.ready = w_en;
    assign w_take      = i_pix.valid && w_en;
    assign w_push      = w_en && r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[1:0], w_take};
        end
    end

    assign w_sample[0] = i_pix.red_in;
    assign w_sample[1] = i_pix.green_in;
    assign w_sample[2] = i_pix.blue_in;

    // In single channel desaturate mode the red sample passes through untouched.
    assign w_bypass = r_mode && !r_rgb;

    // Luminance is formed from all three samples and fed back to every lane at stage 3.
    pitd_luma u_luma (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_red   (i_pix.red_in),
        .i_green (i_pix.green_in),
        .i_blue  (i_pix.blue_in),
        .o_lum   (w_lum)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pitd_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_en       (w_en),
            .i_sample   (w_sample[g]),
            .i_gain     (r_gain[g]),
            .i_invert   (r_invert),
            .i_strength (r_strength),
            .i_mode     (r_mode),
            .i_bypass   (w_bypass),
            .i_lum      (w_lum),
            .o_result   (w_result[g])
        );
    end

    // Merge the lanes: green and blue read as zero for a single channel image.
    always_comb begin
        w_word.red   = w_result[0];
        w_word.green = r_rgb ? w_result[1] : '0;
        w_word.blue  = r_rgb ? w_result[2] : '0;
    end

    pitd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_word),
        .o_space (w_en),
        .o_pix   (o_pix)
    );

`ifndef ASSERT_OFF
    a_stall_needs_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> o_pix.valid)
        else $error("input stalled while the output register is empty");

    a_push_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_pix.valid)
        else $error("pushed word did not reach the output");

    a_stage_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !w_en) |=> r_vld[2])
        else $error("last lane stage lost its word during a stall");
`endif

endmodule

`default_nettype wire

/* verif/pitd_checker.sv */
// Checker for the pixel adjust block: watches all three channels, predicts and compares pixels.
`timescale 1ns / 1ps

module pitd_checker import pitd_pkg::*; #(
    parameter int FRAC_BITS = 15
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pitd_in_if   mon_in,
    pitd_out_if  mon_out,
    pitd_cfg_if  mon_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam int MAX_REPORTS = 200;

    // Local copy of the register file, updated from accepted configuration words.
    logic                mode_sel;
    logic                rgb_en;
    logic [SAMPLE_W-1:0] inv_amt;
    logic [GAIN_W-1:0]   gain_r;
    logic [GAIN_W-1:0]   gain_g;
    logic [GAIN_W-1:0]   gain_b;
    logic [SAMPLE_W-1:0] strength;

    t_pix pix_expected_q[$];
    int   fails = 0;
    int   reports = 0;

    // (a * b) / ONE truncated toward zero; a is never negative.
    function automatic longint mul_trunc(longint a, longint b);
        longint mag;
        longint q;
        mag = (b < 0 ? -b : b) * a;
        q = mag >> FRAC_BITS;
        return (b < 0) ? -q : q;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_unit(longint v);
        if (v < 0) return '0;
        if (v > ONE) return SAMPLE_W'(ONE);
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] tint_lane(logic [SAMPLE_W-1:0] c,
                                                     logic [GAIN_W-1:0] gain);
        longint cv;
        longint v;
        longint p;
        cv = longint'(c);
        v = cv + mul_trunc(longint'(inv_amt), ONE - 2 * cv);
        p = (v < 0) ? -mul_trunc(longint'(gain), -v) : mul_trunc(longint'(gain), v);
        return clamp_unit(p);
    endfunction

    function automatic logic [SAMPLE_W-1:0] mix_lane(logic [SAMPLE_W-1:0] c, longint lum);
        longint cv;
        cv = longint'(c);
        return clamp_unit(cv + mul_trunc(longint'(strength), lum - cv));
    endfunction

    function automatic t_pix adjust_pixel(t_pix px);
        t_pix   res;
        longint lum;
        res = '0;
        if (!mode_sel) begin
            res.red = tint_lane(px.red, gain_r);
            if (rgb_en) begin
                res.green = tint_lane(px.green, gain_g);
                res.blue  = tint_lane(px.blue, gain_b);
            end
        end else if (!rgb_en) begin
            res.red = px.red;
        end else begin
            lum = (longint'(LUMA_R) * longint'(px.red) + longint'(LUMA_G) * longint'(px.green)
                   + longint'(LUMA_B) * longint'(px.blue)) >> 16;
            res.red   = mix_lane(px.red, lum);
            res.green = mix_lane(px.green, lum);
            res.blue  = mix_lane(px.blue, lum);
        end
        return res;
    endfunction

    task automatic check_lane(string lane, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
        if (want !== got) begin
            fails++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, lane, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pix in_px;
        t_pix got;
        t_pix want;
        if (!i_rst_n) begin
            mode_sel = RST_MODE_SELECT;
            rgb_en   = RST_RGB_ENABLE;
            inv_amt  = RST_INVERT_AMOUNT;
            gain_r   = RST_GAIN;
            gain_g   = RST_GAIN;
            gain_b   = RST_GAIN;
            strength = RST_MIX_STRENGTH;
            pix_expected_q.delete();
        end else begin
            if (mon_cfg.valid && mon_cfg.ready) begin
                case (t_cfg_idx'(mon_cfg.index))
                    CFG_MODE_SELECT:   mode_sel = mon_cfg.data[0];
                    CFG_RGB_ENABLE:    rgb_en   = mon_cfg.data[0];
                    CFG_INVERT_AMOUNT: inv_amt  = mon_cfg.data[SAMPLE_W-1:0];
                    CFG_RED_GAIN:      gain_r   = mon_cfg.data[GAIN_W-1:0];
                    CFG_GREEN_GAIN:    gain_g   = mon_cfg.data[GAIN_W-1:0];
                    CFG_BLUE_GAIN:     gain_b   = mon_cfg.data[GAIN_W-1:0];
                    CFG_MIX_STRENGTH:  strength = mon_cfg.data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            if (mon_in.valid && mon_in.ready) begin
                in_px.red   = mon_in.red_in;
                in_px.green = mon_in.green_in;
                in_px.blue  = mon_in.blue_in;
                pix_expected_q.push_back(adjust_pixel(in_px));
            end
            if (mon_out.valid && mon_out.ready) begin
                got.red   = mon_out.red_out;
                got.green = mon_out.green_out;
                got.blue  = mon_out.blue_out;
                if (pix_expected_q.size() == 0) begin
                    fails++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("%0t: unexpected pixel, expected none, actual %0d %0d %0d",
                                 $time, got.red, got.green, got.blue);
                    end
                end else begin
                    want = pix_expected_q.pop_front();
                    check_lane("red_out", want.red, got.red);
                    check_lane("green_out", want.green, got.green);
                    check_lane("blue_out", want.blue, got.blue);
                end
            end
        end
        o_pending    <= pix_expected_q.size();
        o_fail_count <= fails;
    end

endmodule

/* verif/tb.sv */
// Testbench top for the pixel adjust block: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb;
    import pitd_pkg::*;

    localparam int     FRAC = 15;
    localparam longint ONE  = longint'(1) << FRAC;
    localparam int     RANDOM_PIXELS = 1150;

    // Index 7 names no register; a write to it must leave every register alone.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pitd_in_if  pix_in ();
    pitd_out_if pix_out ();
    pitd_cfg_if cfg ();

    int fail_count;
    int pending;

    // When clear, both the sender and the receiver run without any gaps.
    bit idling = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    pixel_invert_tint_desaturate_top #(.FRAC_BITS(FRAC)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_in),
        .o_pix  (pix_out),
        .i_cfg  (cfg)
    );

    pitd_checker #(.FRAC_BITS(FRAC)) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .mon_in      (pix_in),
        .mon_out     (pix_out),
        .mon_cfg     (cfg),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Gap lengths: nine picks in ten from the short range, the rest a long stretch.
    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        if (!idling || $urandom_range(0, 99) < 55) return 0;
        return pick_stall();
    endfunction

    // Samples lean on the corners and the legal range, but the whole 16-bit space
    // shows up too, since values above 1.0 go through the same arithmetic.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return SAMPLE_W'(ONE);
        if (r < 25) return '1;
        if (r < 70) return SAMPLE_W'($urandom_range(0, int'(ONE)));
        return SAMPLE_W'($urandom());
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 35) return CFG_DATA_W'(ONE);
        if (r < 45) return CFG_DATA_W'(16'hFFFF);
        if (r < 85) return CFG_DATA_W'($urandom_range(0, int'(ONE)));
        return CFG_DATA_W'($urandom());
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 30) return CFG_DATA_W'(ONE);
        if (r < 40) return CFG_DATA_W'(2 * ONE);
        if (r < 50) return '1;
        if (r < 85) return CFG_DATA_W'($urandom_range(0, 2 * int'(ONE)));
        return CFG_DATA_W'($urandom());
    endfunction

    // Narrow registers sometimes get junk in the unused upper data bits.
    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] value, int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom()) << width;
        return ($urandom_range(0, 3) == 0) ? (value | junk) : value;
    endfunction

    // Corner pixels for the directed part.
    function automatic t_pix corner_pixel(int k);
        t_pix px;
        case (k)
            0:       px = '{red: 16'd0, green: 16'd0, blue: 16'd0};
            1:       px = '{red: SAMPLE_W'(ONE), green: SAMPLE_W'(ONE), blue: SAMPLE_W'(ONE)};
            2:       px = '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF};
            3:       px = '{red: SAMPLE_W'(ONE), green: 16'd0, blue: 16'hFFFF};
            4:       px = '{red: 16'd1, green: 16'h7FFF, blue: 16'h8001};
            default: px = '{red: 16'hAAAA, green: 16'h5555, blue: 16'h3C3C};
        endcase
        return px;
    endfunction

    // One configuration word. Valid drops after each word so that it never gets
    // two assignments in one time step.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Presents one pixel after an optional idle gap and returns at the edge that
    // accepts it. With no gap, valid stays high straight into the next word.
    task automatic send_pixel(t_pix px, int gap);
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= px.red;
        pix_in.green_in <= px.green;
        pix_in.blue_in  <= px.blue;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
    endtask

    // Holds the sender off until every predicted pixel has come out, then lets
    // the pipeline run empty before any register write.
    task automatic settle();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic randomize_settings();
        write_reg(CFG_MODE_SELECT, with_junk(CFG_DATA_W'($urandom_range(0, 1)), 1));
        write_reg(CFG_RGB_ENABLE,
                  with_junk(CFG_DATA_W'($urandom_range(0, 3) != 0), 1));
        write_reg(CFG_INVERT_AMOUNT, with_junk(pick_weight(), SAMPLE_W));
        write_reg(CFG_RED_GAIN, pick_gain());
        write_reg(CFG_GREEN_GAIN, pick_gain());
        write_reg(CFG_BLUE_GAIN, pick_gain());
        write_reg(CFG_MIX_STRENGTH, with_junk(pick_weight(), SAMPLE_W));
        if ($urandom_range(0, 7) == 0) write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom()));
    endtask

    // The receiver alternates between runs of ready and stalls of random length.
    // While idling is clear it simply keeps ready high.
    initial begin
        int run;
        pix_out.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        forever begin
            run = idling ? $urandom_range(1, 12) : 16;
            pix_out.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (idling) begin
                pix_out.ready <= 1'b0;
                repeat (pick_stall()) @(posedge i_clk);
            end
        end
    end

    initial begin
        int sent;
        int seg_len;
        pix_in.valid    = 1'b0;
        pix_in.red_in   = '0;
        pix_in.green_in = '0;
        pix_in.blue_in  = '0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part. First the reset values: invert and tint at unit gains,
        // which must pass legal samples through and clamp those above 1.0.
        for (int k = 0; k < 6; k++) send_pixel(corner_pixel(k), 0);
        settle();

        // Full inversion with a zero red gain, a green gain of 2.0 and the
        // largest blue gain the register holds, well above its range.
        write_reg(CFG_INVERT_AMOUNT, CFG_DATA_W'(ONE));
        write_reg(CFG_RED_GAIN, '0);
        write_reg(CFG_GREEN_GAIN, CFG_DATA_W'(2 * ONE));
        write_reg(CFG_BLUE_GAIN, '1);
        for (int k = 0; k < 6; k++) send_pixel(corner_pixel(k), 0);
        settle();

        // Full desaturation of an RGB image.
        write_reg(CFG_MODE_SELECT, CFG_DATA_W'(1));
        write_reg(CFG_MIX_STRENGTH, CFG_DATA_W'(ONE));
        for (int k = 0; k < 6; k++) send_pixel(corner_pixel(k), 0);
        settle();

        // Single channel: invert and tint on red with the green and blue lanes
        // forced to zero, then the desaturate pass-through, which must keep
        // samples above 1.0 bit for bit. The write to the spare index in between
        // must change nothing.
        write_reg(CFG_MODE_SELECT, CFG_DATA_W'(0));
        write_reg(CFG_RGB_ENABLE, CFG_DATA_W'(0));
        write_reg(CFG_INVERT_AMOUNT, CFG_DATA_W'(ONE / 2));
        write_reg(CFG_RED_GAIN, CFG_DATA_W'(2 * ONE));
        for (int k = 1; k < 4; k++) send_pixel(corner_pixel(k), 0);
        settle();
        write_reg(CFG_MODE_SELECT, CFG_DATA_W'(1));
        write_reg(CFG_IDX_SPARE, '1);
        for (int k = 2; k < 5; k++) send_pixel(corner_pixel(k), 0);
        settle();

        // Random part in segments. Every segment starts from an empty pipeline
        // with a fresh register setting, and most of them idle on both sides.
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            randomize_settings();
            idling  = ($urandom_range(0, 3) != 0);
            seg_len = $urandom_range(20, 120);
            for (int n = 0; n < seg_len && sent < RANDOM_PIXELS; n++) begin
                send_pixel('{red: pick_sample(), green: pick_sample(), blue: pick_sample()},
                           pick_gap());
                sent++;
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run with every stall at its longest.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
design/pitd_pkg.sv
design/pitd_if.sv
design/pitd_luma.sv
design/pitd_lane.sv
design/pitd_obuf.sv
design/pixel_invert_tint_desaturate_top.sv
verif/pitd_checker.sv
verif/tb.sv
